### sv/button_press_classifier_unit_macros.svh
// Assertion macros for the button press classifier.
// Each expects clk and rst_n to be visible where it is used.
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bpc_pkg.sv
package bpc_pkg;

    // Fixed field widths
    localparam int BTN_IDX_W  = 4;
    localparam int PIN_IDX_W  = 4;
    localparam int PIN_SPAN   = 16;
    localparam int ELAPSED_W  = 32;
    localparam int DUR_W      = 16;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [DUR_W-1:0] DUR_MAX  = 16'hFFFF;
    localparam logic [DUR_W-1:0] DUR_ONE  = 16'h0001;

    localparam logic [DUR_W-1:0] CLICK_THR_RST = 16'd50;
    localparam logic [DUR_W-1:0] LONG_THR_RST  = 16'd1000;

    // Event queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    typedef enum logic [1:0] {
        KIND_PRESSED   = 2'd0,
        KIND_RELEASED  = 2'd1,
        KIND_CLICK     = 2'd2,
        KIND_LONGCLICK = 2'd3
    } event_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_COUNT = 3'd0,
        CFG_PIN_MAP      = 3'd1,
        CFG_ACTIVE_MASK  = 3'd2,
        CFG_PAUSE_MASK   = 3'd3,
        CFG_CLICK_THR    = 3'd4,
        CFG_LONG_THR     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                 last;
        logic [BTN_IDX_W-1:0] index;
        event_kind_t          kind;
    } evt_t;

    typedef struct packed {
        logic push;
        evt_t evt;
    } evt_req_t;

endpackage

### sv/bpc_front.sv
module bpc_front
    import bpc_pkg::*;
#(
    parameter int MAX_BUTTONS = 10,
    parameter int PIN_COUNT   = 16,
    parameter int PM_W        = 4 * MAX_BUTTONS,
    parameter int CFG_W       = (PM_W > DUR_W) ? PM_W : DUR_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // sample request
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIN_COUNT-1:0] pin_levels,
    input  logic [ELAPSED_W-1:0] elapsed_ms,
    // event push into queue
    output evt_req_t             q_req,
    input  logic                 q_full
);

    localparam int CNT_W = $clog2(MAX_BUTTONS + 1);
    localparam int BTN_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    // Configuration registers
    logic [COUNT_W-1:0]     button_count_reg;
    logic [PM_W-1:0]        pin_map_reg;
    logic [MAX_BUTTONS-1:0] active_mask_reg;
    logic [MAX_BUTTONS-1:0] pause_mask_reg;
    logic [DUR_W-1:0]       click_thr_reg;
    logic [DUR_W-1:0]       long_thr_reg;

    // Scan state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [PIN_COUNT-1:0]   levels_reg;
    logic [ELAPSED_W-1:0]   elapsed_reg;
    logic                   pend_valid_reg, pend_valid_next;
    evt_t                   pend_reg, pend_next;
    logic [DUR_W-1:0]       dur_reg [MAX_BUTTONS];

    logic                   accept;
    logic                   at_end;
    logic                   dur_we;
    logic [BTN_W-1:0]       cur;
    logic [PIN_IDX_W-1:0]   pin;
    logic [PIN_SPAN-1:0]    lvl_ext;
    logic                   lvl, act, paused;
    logic [DUR_W-1:0]       dur, sat, new_dur;
    logic [ELAPSED_W:0]     sum;
    logic                   ev_valid;
    event_kind_t            ev_kind;
    logic [CNT_W-1:0]       n_calc;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_count_reg <= '0;
            pin_map_reg      <= '0;
            active_mask_reg  <= '0;
            pause_mask_reg   <= '0;
            click_thr_reg    <= CLICK_THR_RST;
            long_thr_reg     <= LONG_THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUTTON_COUNT: button_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_PIN_MAP:      pin_map_reg      <= cfg_data[PM_W-1:0];
                CFG_ACTIVE_MASK:  active_mask_reg  <= cfg_data[MAX_BUTTONS-1:0];
                CFG_PAUSE_MASK:   pause_mask_reg   <= cfg_data[MAX_BUTTONS-1:0];
                CFG_CLICK_THR:    click_thr_reg    <= cfg_data[DUR_W-1:0];
                CFG_LONG_THR:     long_thr_reg     <= cfg_data[DUR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pin levels widened to the reach of a pin index; missing pins read low
    for (genvar k = 0; k < PIN_SPAN; k++)
    begin : g_lvl
        if (k < PIN_COUNT)
        begin : g_have
            assign lvl_ext[k] = levels_reg[k];
        end
        else
        begin : g_none
            assign lvl_ext[k] = 1'b0;
        end
    end

    // Button count clamped to the number of duration slots
    always_comb
    begin
        if (int'(button_count_reg) > MAX_BUTTONS)
            n_calc = CNT_W'(MAX_BUTTONS);
        else
            n_calc = CNT_W'(button_count_reg);
    end

    // Current button lookup and duration update
    assign cur    = cnt_reg[BTN_W-1:0];
    assign at_end = (cnt_reg >= n_reg);
    assign pin    = pin_map_reg[{cur, 2'b00} +: PIN_IDX_W];
    assign lvl    = lvl_ext[pin];
    assign act    = active_mask_reg[cur];
    assign paused = pause_mask_reg[cur];
    assign dur    = dur_reg[cur];
    assign sum    = {{(ELAPSED_W + 1 - DUR_W){1'b0}}, dur} + {1'b0, elapsed_reg};
    assign sat    = (sum >= {{(ELAPSED_W + 1 - DUR_W){1'b0}}, DUR_MAX}) ? DUR_MAX
                                                                        : sum[DUR_W-1:0];

    always_comb
    begin
        new_dur  = dur;
        ev_valid = 1'b0;
        ev_kind  = KIND_PRESSED;
        if (lvl == act)
        begin
            if (dur != '0)
                new_dur = sat;
            else
            begin
                new_dur  = DUR_ONE;
                ev_valid = !paused;
            end
        end
        else if (dur != '0)
        begin
            new_dur  = '0;
            ev_valid = !paused;
            priority if (sat >= long_thr_reg)
                ev_kind = KIND_LONGCLICK;
            else if (sat >= click_thr_reg)
                ev_kind = KIND_CLICK;
            else
                ev_kind = KIND_RELEASED;
        end
    end

    // Scan sequencer: one button per cycle but stalled by a full queue;
    // the newest event is held until it is known if it is the sample's last
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        dur_we          = 1'b0;
        q_req.push      = 1'b0;
        q_req.evt       = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next      = ST_SCAN;
                    cnt_next        = '0;
                    n_next          = n_calc;
                    pend_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (at_end)
                begin
                    q_req.evt.last = 1'b1;
                    if (!(pend_valid_reg && q_full))
                    begin
                        q_req.push      = pend_valid_reg;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else if (!(ev_valid && pend_valid_reg && q_full))
                begin
                    q_req.evt.last = 1'b0;
                    q_req.push     = ev_valid && pend_valid_reg;
                    dur_we         = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (ev_valid)
                    begin
                        pend_valid_next = 1'b1;
                        pend_next.kind  = ev_kind;
                        pend_next.index = BTN_IDX_W'(cur);
                        pend_next.last  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Sample and pending event payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            levels_reg  <= pin_levels;
            elapsed_reg <= elapsed_ms;
        end
        pend_reg <= pend_next;
    end

    // Hold durations, all released after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < MAX_BUTTONS; b++)
                dur_reg[b] <= '0;
        end
        else if (dur_we)
        begin
            dur_reg[cur] <= new_dur;
        end
    end

endmodule

### sv/bpc_event_queue.sv
module bpc_event_queue
    import bpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    // push side
    input  evt_req_t q_req,
    output logic     q_full,
    // delivery side
    output logic     out_valid,
    input  logic     out_ready,
    output evt_t     out_evt
);

    evt_t               entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               push, pop;

    assign q_full    = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_evt   = entry_reg[rd_ptr_reg];
    assign push      = q_req.push && !q_full;
    assign pop       = out_valid && out_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + Q_CNT_W'(1);
                2'b01:   count_reg <= count_reg - Q_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= q_req.evt;
    end

endmodule

### sv/button_press_classifier_unit.sv
// Button press classifier. Each sample request carries the levels of the
// input pins and the milliseconds since the previous sample. The first
// button_count buttons are visited one per clock cycle in index order
// while the event queue has room; each new press gives PRESSED, each
// release gives RELEASED, CLICK or LONGCLICK by its held time unless the
// button is paused, and the final event of a sample is marked by tlast.
// A new sample is accepted only once the scan of the previous one has
// ended; the scan pace is set by the single shared read and update port
// of the hold duration registers. Events wait in a four-entry queue, so
// the scan runs on while the consumer stalls and stalls only when the
// queue is full. Configuration writes take effect at once, so write them
// only while no sample is in flight.
`include "button_press_classifier_unit_macros.svh"

module button_press_classifier_unit
    import bpc_pkg::*;
#(
    parameter int MAX_BUTTONS  = 10,
    parameter int PIN_COUNT    = 16,
    localparam int PM_W        = 4 * MAX_BUTTONS,
    localparam int CFG_W       = (PM_W > DUR_W) ? PM_W : DUR_W,
    localparam int IN_W        = ((PIN_COUNT + ELAPSED_W + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // samples
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // pin_levels, elapsed_ms
    // events
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // button_index
    output logic [1:0]           m_axis_tuser,   // event_kind
    output logic                 m_axis_tlast    // last_event
);

    evt_req_t q_req;
    logic     q_full;
    evt_t     out_evt;

    // Front: sample intake and per-button classification
    bpc_front #(
        .MAX_BUTTONS (MAX_BUTTONS),
        .PIN_COUNT   (PIN_COUNT),
        .PM_W        (PM_W),
        .CFG_W       (CFG_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .pin_levels (s_axis_tdata[PIN_COUNT-1:0]),
        .elapsed_ms (s_axis_tdata[PIN_COUNT+ELAPSED_W-1:PIN_COUNT]),
        .q_req      (q_req),
        .q_full     (q_full)
    );

    // Back: event queue feeding the output stream
    bpc_event_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_req     (q_req),
        .q_full    (q_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_evt   (out_evt)
    );

    assign m_axis_tdata = {{(8 - BTN_IDX_W){1'b0}}, out_evt.index};
    assign m_axis_tuser = out_evt.kind;
    assign m_axis_tlast = out_evt.last;

    // Checks
    `BPC_ASSERT_SAME(a_no_push_when_full, q_req.push, !q_full, "push into full queue")
    `BPC_ASSERT_NEXT(a_busy_after_sample, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy")
    `BPC_ASSERT_SAME(a_index_in_range, m_axis_tvalid, int'(m_axis_tdata) < MAX_BUTTONS, "index")

endmodule
